[design/base64url_address_checker_assert.svh]
// Assertion macros used by the checker module.
`ifndef BASE64URL_ADDRESS_CHECKER_ASSERT_SVH
`define BASE64URL_ADDRESS_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64U_ASSERT_NOW(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("b64u assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B64U_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("b64u assertion failed");

`endif

[design/b64u_pkg.sv]
package b64u_pkg;

  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam logic [7:0]  TagMask   = 8'h7F;
  localparam logic [7:0]  TagBounce = 8'h11;
  localparam logic [7:0]  TagPlain  = 8'h51;
  localparam logic [5:0]  AddrChars = 6'd48;
  localparam logic [5:0]  AddrBytes = 6'd36;
  localparam logic [5:0]  CrcBytes  = 6'd34;
  localparam logic [5:0]  CrcHiIdx  = 6'd34;
  localparam logic [5:0]  CrcLoIdx  = 6'd35;
  localparam logic [5:0]  CountMax  = 6'd63;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_BAD_CHAR = 3'd2,
    ST_BAD_TAG  = 3'd3,
    ST_BAD_CRC  = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_t;

  typedef struct packed {
    logic              valid_res;
    logic [2:0]        status;
    logic [7:0]        tag_value;
    logic signed [7:0] workchain;
  } out_t;

  typedef struct packed {
    logic [5:0] value;
    logic       bad;
  } sext_t;

  // One byte of CRC16-XMODEM, MSB first.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] r;
    r = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

[design/b64u_sextet.sv]
module b64u_sextet (
  input  logic [7:0]     char_i,
  output b64u_pkg::sext_t sext_o
);
  import b64u_pkg::*;

  // Map a URL-safe base64 character to its six-bit value; flag anything else.
  always_comb begin
    sext_o.value = 6'd0;
    sext_o.bad   = 1'b0;
    if (char_i inside {[8'h41:8'h5A]}) begin
      sext_o.value = 6'(char_i - 8'h41);
    end else if (char_i inside {[8'h61:8'h7A]}) begin
      sext_o.value = 6'(char_i - 8'h61 + 8'd26);
    end else if (char_i inside {[8'h30:8'h39]}) begin
      sext_o.value = 6'(char_i - 8'h30 + 8'd52);
    end else if (char_i == 8'h2D) begin
      sext_o.value = 6'd62;
    end else if (char_i == 8'h5F) begin
      sext_o.value = 6'd63;
    end else begin
      sext_o.bad = 1'b1;
    end
  end

endmodule

[design/b64u_core.sv]
module b64u_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            last_i,
  input  b64u_pkg::sext_t sext_i,
  output b64u_pkg::out_t  res_o
);
  import b64u_pkg::*;

  logic [5:0]  pend_bits_q, pend_bits_d;
  logic [2:0]  pend_cnt_q, pend_cnt_d;
  logic [5:0]  char_cnt_q, char_cnt_d;
  logic        bad_q, bad_d;
  logic [5:0]  byte_idx_q, byte_idx_d;
  logic [7:0]  tag_q, tag_d;
  logic [7:0]  wc_q, wc_d;
  logic [15:0] crc_run_q, crc_run_d;
  logic [15:0] crc_rx_q, crc_rx_d;

  logic [11:0] acc;
  logic [3:0]  cnt6;
  logic [2:0]  shift;
  logic [11:0] rem_mask;
  logic [7:0]  byte_val;
  logic        byte_en;
  logic        take;
  logic [7:0]  tag_base;
  status_e     status;

  always_comb begin
    char_cnt_d = (char_cnt_q != CountMax) ? char_cnt_q + 6'd1 : char_cnt_q;
    bad_d      = bad_q | sext_i.bad;

    // Pack the new six bits behind the pending ones; emit a byte at eight.
    acc      = {pend_bits_q, sext_i.value};
    cnt6     = {1'b0, pend_cnt_q} + 4'd6;
    byte_en  = cnt6 >= 4'd8;
    shift    = byte_en ? 3'(cnt6 - 4'd8) : 3'(cnt6);
    byte_val = 8'(acc >> shift);
    rem_mask = (12'd1 << shift) - 12'd1;
    pend_bits_d = byte_en ? 6'(acc & rem_mask) : sext_i.value;
    pend_cnt_d  = shift;

    byte_idx_d = byte_idx_q;
    tag_d      = tag_q;
    wc_d       = wc_q;
    crc_run_d  = crc_run_q;
    crc_rx_d   = crc_rx_q;
    take       = byte_en && (byte_idx_q < AddrBytes);
    if (take) begin
      byte_idx_d = byte_idx_q + 6'd1;
      if (byte_idx_q == 6'd0) begin
        tag_d = byte_val;
      end
      if (byte_idx_q == 6'd1) begin
        wc_d = byte_val;
      end
      if (byte_idx_q < CrcBytes) begin
        crc_run_d = crc_byte(crc_run_q, byte_val);
      end
      if (byte_idx_q == CrcHiIdx) begin
        crc_rx_d = {byte_val, crc_rx_q[7:0]};
      end
      if (byte_idx_q == CrcLoIdx) begin
        crc_rx_d = {crc_rx_q[15:8], byte_val};
      end
    end

    // Checks in priority order, on the state after this character.
    tag_base = tag_d & TagMask;
    if (char_cnt_d != AddrChars) begin
      status = ST_BAD_LEN;
    end else if (bad_d) begin
      status = ST_BAD_CHAR;
    end else if (tag_base != TagBounce && tag_base != TagPlain) begin
      status = ST_BAD_TAG;
    end else if (crc_run_d != crc_rx_d) begin
      status = ST_BAD_CRC;
    end else begin
      status = ST_OK;
    end

    res_o.valid_res = (status == ST_OK);
    res_o.status    = status;
    res_o.tag_value = tag_d;
    res_o.workchain = wc_d;
  end

  // Advance on each word; clear everything after the final one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      char_cnt_q  <= '0;
      bad_q       <= 1'b0;
      byte_idx_q  <= '0;
      tag_q       <= '0;
      wc_q        <= '0;
      crc_run_q   <= '0;
      crc_rx_q    <= '0;
    end else if (step_i) begin
      if (last_i) begin
        pend_bits_q <= '0;
        pend_cnt_q  <= '0;
        char_cnt_q  <= '0;
        bad_q       <= 1'b0;
        byte_idx_q  <= '0;
        tag_q       <= '0;
        wc_q        <= '0;
        crc_run_q   <= '0;
        crc_rx_q    <= '0;
      end else begin
        pend_bits_q <= pend_bits_d;
        pend_cnt_q  <= pend_cnt_d;
        char_cnt_q  <= char_cnt_d;
        bad_q       <= bad_d;
        byte_idx_q  <= byte_idx_d;
        tag_q       <= tag_d;
        wc_q        <= wc_d;
        crc_run_q   <= crc_run_d;
        crc_rx_q    <= crc_rx_d;
      end
    end
  end

endmodule

[design/base64url_address_checker.sv]
// Address checker: URL-safe base64 decode of an address string with a
// CRC16-XMODEM check over decoded bytes 0..33 against bytes 34..35.
//
// Input channel: one character word per accepted handshake, in_data_i.last
// marks the final character. Output channel: one result word for every
// input word with last set; other words produce no result.
//
// Pipeline: an input register, then combinational decode, bit packing and
// a one-byte CRC update, then the result register. out_valid_o rises as a
// final character leaves the input register. Throughput is one character
// per cycle, except that a final character waits while a result is stalled;
// the eight-step CRC byte update sets the longest path.
//
// Reset clears both valid flags and all decode state; state also returns
// to its reset value after every final character. When the receiver
// stalls, the result word holds and non-final characters keep flowing
// through the input register; a final character waits there, with
// in_ready_o low, until the result register drains.
module base64url_address_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  b64u_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output b64u_pkg::out_t out_data_o
);
  import b64u_pkg::*;

  logic  in_valid_q;
  in_t   in_q;
  logic  out_valid_q;
  out_t  out_q;
  logic  advance;
  logic  out_free;
  sext_t sext;
  out_t  res;

  // The input word moves on unless it would produce a result while the
  // result register is still full.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!in_q.last || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Hold the input word until it advances.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  b64u_sextet u_sextet (
    .char_i (in_q.char_code),
    .sext_o (sext)
  );

  b64u_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .last_i (in_q.last),
    .sext_i (sext),
    .res_o  (res)
  );

  // Result register: load on a final character, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_q.last) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[design/b64u_chk.sv]
`include "base64url_address_checker_assert.svh"

module b64u_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input b64u_pkg::out_t out_data_o
);
  import b64u_pkg::*;

  logic [7:0] tag_base;
  logic       stalled;

  assign tag_base = out_data_o.tag_value & TagMask;
  assign stalled  = out_valid_o && !out_ready_i;

  // A stalled result stays offered.
  `B64U_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_o)

  // A stalled result keeps its word.
  `B64U_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, stalled, $stable(out_data_o))

  // The pass flag agrees with the status code.
  `B64U_ASSERT_NOW(a_pass_flag, clk_i, rst_ni, out_valid_o,
    out_data_o.valid_res == (out_data_o.status == ST_OK))

  // A passing address carries one of the two known tags.
  `B64U_ASSERT_NOW(a_pass_tag, clk_i, rst_ni, out_valid_o && out_data_o.valid_res,
    tag_base == TagBounce || tag_base == TagPlain)

  // With no result pending the input side is always open.
  `B64U_ASSERT_NOW(a_in_open, clk_i, rst_ni, !out_valid_o, in_ready_o)

endmodule

bind base64url_address_checker b64u_chk u_chk (.*);

[dv/base64url_address_checker_tb.sv]
`timescale 1ns / 100ps

// Self-checking bench for the base64url address checker.
//
// Address strings go in one character word at a time, and the final
// character carries the last flag. A predictor in this bench decodes every
// accepted word the way the block should: sextet lookup, MSB-first byte
// packing, CRC16-XMODEM over bytes 0..33, capture of tag, workchain and the
// received CRC. Each final character queues one expected result word. The
// checker compares every accepted result word field by field with the
// oldest expectation.
//
// Stimulus runs as a series of test tasks:
//   directed      - good addresses with every tag variant and the workchain
//                   extremes, bad tag, bad CRC, illegal characters at both
//                   ends, short and long strings, count saturation, a lone
//                   final character and a sweep of the whole alphabet
//   random mix    - mostly well-formed addresses with random content, the
//                   rest broken on purpose or plain noise
//   input stall   - receiver holds off for a long stretch while the sender
//                   keeps offering words, so the block fills and drops ready
//   drain pauses  - sender waits until every expected result is back
//   no idle       - closing part with neither side idling
module base64url_address_checker_tb;
  import b64u_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int LongHold     = 300;
  localparam int RandomChars  = 40;
  localparam int SettleCycles = 10;

  // Alphabet anchors: 'A', 'a', '0', '-', '_'.
  localparam logic [7:0] ChUpA  = 8'h41;
  localparam logic [7:0] ChLoA  = 8'h61;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChDash = 8'h2D;
  localparam logic [7:0] ChUnd  = 8'h5F;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  // Idle controls, shared between the stimulus and the receiver process.
  bit tx_gaps       = 1'b1;
  bit rx_gaps       = 1'b1;
  bit long_hold_req = 1'b0;

  int mismatches = 0;
  int cycles_run = 0;
  int chars_sent = 0;

  // Results the block owes, oldest first.
  out_t expected_results[$];
  // Character string under construction for the next send.
  logic [7:0] addr_chars[$];

  // Decoder state mirrored by the predictor.
  logic [5:0]  acc_bits     = '0;
  logic [2:0]  acc_count    = '0;
  logic [5:0]  chars_seen   = '0;
  logic        illegal_seen = 1'b0;
  logic [5:0]  bytes_out    = '0;
  logic [7:0]  tag_byte     = '0;
  logic [7:0]  wc_byte      = '0;
  logic [15:0] crc_calc     = '0;
  logic [15:0] crc_rx       = '0;

  base64url_address_checker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Sextet value of a character, -1 outside the URL-safe alphabet.
  function automatic int decode_sextet(logic [7:0] c);
    if (c >= ChUpA && c <= ChUpA + 8'd25) return int'(c - ChUpA);
    if (c >= ChLoA && c <= ChLoA + 8'd25) return int'(c - ChLoA) + 26;
    if (c >= ChZero && c <= ChZero + 8'd9) return int'(c - ChZero) + 52;
    if (c == ChDash) return 62;
    if (c == ChUnd) return 63;
    return -1;
  endfunction

  function automatic logic [7:0] sextet_char(logic [5:0] s);
    if (s < 6'd26) return ChUpA + 8'(s);
    if (s < 6'd52) return ChLoA + 8'(s - 6'd26);
    if (s < 6'd62) return ChZero + 8'(s - 6'd52);
    if (s == 6'd62) return ChDash;
    return ChUnd;
  endfunction

  // Bit-serial CRC16-XMODEM update, data MSB first.
  function automatic logic [15:0] xmodem_update(logic [15:0] crc, logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ data[i];
      r  = {r[14:0], 1'b0};
      if (fb) r = r ^ CrcPoly;
    end
    return r;
  endfunction

  // Advance the mirrored decoder by one accepted character word; on the
  // final character queue the expected result and clear the state.
  function automatic void absorb_char(logic [7:0] code, logic fin);
    int          v;
    int          cnt;
    logic [11:0] acc;
    logic [7:0]  b;
    logic [7:0]  base;
    out_t        res;
    status_e     st;
    v = decode_sextet(code);
    if (v < 0) begin
      illegal_seen = 1'b1;
      v = 0;
    end
    if (chars_seen != CountMax) chars_seen++;

    acc = {acc_bits, 6'(v)};
    cnt = int'(acc_count) + 6;
    if (cnt >= 8) begin
      cnt -= 8;
      b = acc[cnt +: 8];
      // Bytes past the 36th are dropped.
      if (bytes_out < AddrBytes) begin
        if (bytes_out == 6'd0) tag_byte = b;
        if (bytes_out == 6'd1) wc_byte = b;
        if (bytes_out < CrcBytes) crc_calc = xmodem_update(crc_calc, b);
        if (bytes_out == CrcHiIdx) crc_rx[15:8] = b;
        if (bytes_out == CrcLoIdx) crc_rx[7:0] = b;
        bytes_out++;
      end
      acc = acc & ((12'd1 << cnt) - 12'd1);
    end
    acc_bits  = acc[5:0];
    acc_count = 3'(cnt);

    if (!fin) return;

    base = tag_byte & TagMask;
    if (chars_seen != AddrChars) st = ST_BAD_LEN;
    else if (illegal_seen) st = ST_BAD_CHAR;
    else if (base != TagBounce && base != TagPlain) st = ST_BAD_TAG;
    else if (crc_calc != crc_rx) st = ST_BAD_CRC;
    else st = ST_OK;

    res.valid_res = (st == ST_OK);
    res.status    = st;
    res.tag_value = tag_byte;
    res.workchain = wc_byte;
    expected_results.push_back(res);

    acc_bits     = '0;
    acc_count    = '0;
    chars_seen   = '0;
    illegal_seen = 1'b0;
    bytes_out    = '0;
    tag_byte     = '0;
    wc_byte      = '0;
    crc_calc     = '0;
    crc_rx       = '0;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Sample result words at the rising edge; outputs hold their pre-edge value.
  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing expected", 32'(out_data_o), '0);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.valid_res !== want.valid_res)
          report_mismatch("valid_res", 32'(out_data_o.valid_res), 32'(want.valid_res));
        if (out_data_o.status !== want.status)
          report_mismatch("status", 32'(out_data_o.status), 32'(want.status));
        if (out_data_o.tag_value !== want.tag_value)
          report_mismatch("tag_value", 32'(out_data_o.tag_value), 32'(want.tag_value));
        if (out_data_o.workchain !== want.workchain)
          report_mismatch("workchain", 32'(out_data_o.workchain), 32'(want.workchain));
      end
    end
  end

  // Bail out if the run hangs.
  initial begin
    while (cycles_run < CycleLimit) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, or one long hold when requested.
  // ---------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        // Hold off long enough for the block to back up into its input.
        out_ready_i <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        long_hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // Offer one character word; drive at the falling edge, hold until taken.
  task automatic send_word(input logic [7:0] code, input logic fin);
    @(negedge clk_i);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= in_t'{char_code: code, last: fin};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    absorb_char(code, fin);
    chars_sent++;
  endtask

  // Send the staged string, flagging its final character.
  task automatic send_addr();
    foreach (addr_chars[i]) send_word(addr_chars[i], i == addr_chars.size() - 1);
  endtask

  // Stop offering, then wait until every owed result has been taken.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] legal_char();
    return sextet_char(6'($urandom_range(0, 63)));
  endfunction

  function automatic logic [7:0] illegal_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (decode_sextet(c) >= 0);
    return c;
  endfunction

  // One of the four accepted tag encodings: plain or bounce, test flag or not.
  function automatic logic [7:0] good_tag();
    case ($urandom_range(0, 3))
      0: return TagBounce;
      1: return TagPlain;
      2: return TagBounce | 8'h80;
      default: return TagPlain | 8'h80;
    endcase
  endfunction

  function automatic logic [7:0] bad_tag();
    logic [7:0] t;
    do t = 8'($urandom); while ((t & TagMask) == TagBounce || (t & TagMask) == TagPlain);
    return t;
  endfunction

  // Stage a 48-character address: tag, workchain, random body, CRC.
  task automatic make_address(input logic [7:0] tag, input logic [7:0] wc,
                              input bit crc_ok);
    logic [287:0] bits;
    logic [15:0]  crc;
    logic [7:0]   b;
    crc = '0;
    for (int i = 0; i < 34; i++) begin
      b = (i == 0) ? tag : (i == 1) ? wc : 8'($urandom);
      bits[287 - 8*i -: 8] = b;
      crc = xmodem_update(crc, b);
    end
    if (!crc_ok) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    bits[15:0] = crc;
    addr_chars = {};
    for (int k = 0; k < 48; k++) addr_chars.push_back(sextet_char(bits[287 - 6*k -: 6]));
  endtask

  // Mostly well-formed addresses; the rest broken in one way or noise.
  task automatic send_random_string();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      make_address(good_tag(), 8'($urandom), 1'b1);
    end else if (pick < 65) begin
      make_address(good_tag(), 8'($urandom), 1'b0);
    end else if (pick < 73) begin
      make_address(bad_tag(), 8'($urandom), 1'($urandom_range(0, 1)));
    end else if (pick < 83) begin
      make_address(good_tag(), 8'($urandom), 1'b1);
      addr_chars[$urandom_range(0, 47)] = illegal_char();
    end else if (pick < 93) begin
      // Truncate or extend a good address to a wrong length.
      do len = $urandom_range(1, 70); while (len == 48);
      make_address(good_tag(), 8'($urandom), 1'b1);
      while (addr_chars.size() > len) void'(addr_chars.pop_back());
      while (addr_chars.size() < len) addr_chars.push_back(legal_char());
    end else begin
      len = $urandom_range(1, 60);
      addr_chars = {};
      repeat (len) addr_chars.push_back(8'($urandom_range(0, 255)));
    end
    send_addr();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_directed();
    // Good addresses, all tag flavors, workchain extremes.
    make_address(TagBounce, 8'h00, 1'b1);
    send_addr();
    make_address(TagPlain, 8'hFF, 1'b1);
    send_addr();
    make_address(TagBounce | 8'h80, 8'h80, 1'b1);
    send_addr();
    make_address(TagPlain | 8'h80, 8'h7F, 1'b1);
    send_addr();
    // Bad tags at both ends of the byte range.
    make_address(8'h00, 8'h00, 1'b1);
    send_addr();
    make_address(8'hFF, 8'hFF, 1'b1);
    send_addr();
    // Bad CRC.
    make_address(TagBounce, 8'h00, 1'b0);
    send_addr();
    // Illegal characters: code 0 first, code 255 last, a high code inside.
    make_address(TagPlain, 8'h00, 1'b1);
    addr_chars[0] = 8'h00;
    send_addr();
    make_address(TagPlain, 8'h00, 1'b1);
    addr_chars[47] = 8'hFF;
    send_addr();
    make_address(TagBounce, 8'h00, 1'b1);
    addr_chars[20] = 8'h80;
    send_addr();
    // One short, one long.
    make_address(TagBounce, 8'h00, 1'b1);
    void'(addr_chars.pop_back());
    send_addr();
    make_address(TagBounce, 8'h00, 1'b1);
    addr_chars.push_back(ChUpA);
    send_addr();
    // 112 characters: a wrapping count would land on 48, saturation must not.
    make_address(TagBounce, 8'h00, 1'b1);
    repeat (64) addr_chars.push_back(legal_char());
    send_addr();
    // Lone final character.
    send_word(ChUnd, 1'b1);
    // Whole alphabet in order.
    addr_chars = {};
    for (int s = 0; s < 64; s++) addr_chars.push_back(sextet_char(6'(s)));
    send_addr();
  endtask

  task automatic test_random_mix();
    int goal;
    goal = chars_sent + RandomChars;
    while (chars_sent < goal) begin
      // Flip idling now and then so some stretches run without gaps.
      if ($urandom_range(0, 9) == 0) tx_gaps = ~tx_gaps;
      if ($urandom_range(0, 9) == 0) rx_gaps = ~rx_gaps;
      send_random_string();
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_input_stall();
    // Keep offering words back to back while the receiver is held off.
    tx_gaps = 1'b0;
    long_hold_req = 1'b1;
    repeat (8) send_word(legal_char(), 1'b1);
    send_random_string();
    wait_drained();
    tx_gaps = 1'b1;
  endtask

  task automatic test_drain_pauses();
    repeat (2) begin
      send_random_string();
      send_word(illegal_char(), 1'b1);
      wait_drained();
    end
  endtask

  task automatic test_no_idle();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (2) send_random_string();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_mix();
    test_input_stall();
    test_drain_pauses();
    test_no_idle();

    // Drop valid, collect what is still owed, then let the pipe settle.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/b64u_pkg.sv
design/b64u_sextet.sv
design/b64u_core.sv
design/base64url_address_checker.sv
design/b64u_chk.sv
dv/base64url_address_checker_tb.sv
